// File: rtl/geqi_pkg.sv
// shared types, codes and vector decode functions for the exception slot
`timescale 1ns / 1ps

package geqi_pkg;

  localparam int VecW = 8;
  localparam int SlotVecW = 5;
  localparam int ErrW = 32;
  localparam int StatusW = 3;

  // item opcodes
  localparam logic OP_QUEUE  = 1'b0;
  localparam logic OP_INJECT = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_QUEUED   = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID  = 3'd1;
  localparam logic [StatusW-1:0] ST_TRIPLE   = 3'd2;
  localparam logic [StatusW-1:0] ST_INJECTED = 3'd3;
  localparam logic [StatusW-1:0] ST_NONE     = 3'd4;
  localparam logic [StatusW-1:0] ST_SHUTDOWN = 3'd5;

  // exception classes
  localparam logic [1:0] CLS_BENIGN = 2'd1;
  localparam logic [1:0] CLS_CONT   = 2'd2;
  localparam logic [1:0] CLS_PF     = 2'd3;

  localparam logic [SlotVecW-1:0] VEC_DF = 5'd8;
  localparam logic [2:0] TYPE_HW_EXC = 3'd3;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [SlotVecW-1:0] slot_vector;
    logic [31:0]         entry_info;
    logic [ErrW-1:0]     entry_error_code;
    logic                write_error_code;
    logic                retain_rip;
    logic                set_resume_flag;
  } res_t;

  function automatic logic [1:0] class_of(input logic [SlotVecW-1:0] v);
    logic [1:0] c;
    case (v)
      5'd0, 5'd10, 5'd11, 5'd12, 5'd13: c = CLS_CONT;
      5'd14, 5'd20:                     c = CLS_PF;
      default:                          c = CLS_BENIGN;
    endcase
    return c;
  endfunction

  function automatic logic has_error_code(input logic [SlotVecW-1:0] v);
    return (v == 5'd8) || (v inside {[5'd10:5'd14]}) || (v == 5'd17);
  endfunction

  // traps, nmi and aborts are not faults
  function automatic logic is_fault(input logic [SlotVecW-1:0] v);
    return !(v inside {5'd1, 5'd2, 5'd3, 5'd4, 5'd8, 5'd18});
  endfunction

endpackage

// File: rtl/geqi_core.sv
// pending exception slot state and the per-item decision logic
`timescale 1ns / 1ps

module geqi_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          opcode,
  input  logic [geqi_pkg::VecW-1:0]     vector,
  input  logic [geqi_pkg::ErrW-1:0]     error_code,
  output geqi_pkg::res_t                res
);
  import geqi_pkg::*;

  logic                slot_valid;
  logic [SlotVecW-1:0] slot_vector_reg;
  logic [ErrW-1:0]     slot_error;
  logic                shutdown_pending;

  logic                slot_valid_next;
  logic [SlotVecW-1:0] slot_vector_next;
  logic [ErrW-1:0]     slot_error_next;
  logic                shutdown_pending_next;

  logic [SlotVecW-1:0] new_vec;
  logic [1:0]          pend_class;
  logic [1:0]          item_class;
  logic                promote;
  logic                ec;

  assign new_vec    = vector[SlotVecW-1:0];
  assign pend_class = slot_valid ? class_of(slot_vector_reg) : CLS_BENIGN;
  assign item_class = class_of(new_vec);
  assign promote    = ((pend_class == CLS_CONT) && (item_class == CLS_CONT)) ||
                      ((pend_class == CLS_PF) && (item_class != CLS_BENIGN));
  assign ec         = has_error_code(slot_vector_reg);

  always_comb begin
    slot_valid_next       = slot_valid;
    slot_vector_next      = slot_vector_reg;
    slot_error_next       = slot_error;
    shutdown_pending_next = shutdown_pending;
    res                   = '0;
    if (opcode == OP_QUEUE) begin
      if (vector[VecW-1:SlotVecW] != '0) begin
        res.status = ST_INVALID;
      end else if (slot_valid && (slot_vector_reg == VEC_DF) &&
                   (item_class != CLS_BENIGN)) begin
        shutdown_pending_next = 1'b1;
        res.status            = ST_TRIPLE;
      end else begin
        slot_valid_next = 1'b1;
        if (promote) begin
          slot_vector_next = VEC_DF;
          slot_error_next  = '0;
        end else begin
          slot_vector_next = new_vec;
          slot_error_next  = has_error_code(new_vec) ? error_code : '0;
        end
        res.status = ST_QUEUED;
      end
    end else begin
      if (shutdown_pending) begin
        shutdown_pending_next = 1'b0;
        res.status            = ST_SHUTDOWN;
      end else if (!slot_valid) begin
        res.status = ST_NONE;
      end else begin
        res.entry_info       = {1'b1, 19'd0, ec, TYPE_HW_EXC,
                                {(8-SlotVecW){1'b0}}, slot_vector_reg};
        res.entry_error_code = ec ? slot_error : '0;
        res.write_error_code = ec;
        res.retain_rip       = is_fault(slot_vector_reg);
        res.set_resume_flag  = is_fault(slot_vector_reg);
        slot_valid_next      = 1'b0;
        slot_vector_next     = '0;
        slot_error_next      = '0;
        res.status           = ST_INJECTED;
      end
    end
    res.slot_vector = slot_valid_next ? slot_vector_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid       <= 1'b0;
      slot_vector_reg  <= '0;
      slot_error       <= '0;
      shutdown_pending <= 1'b0;
    end else if (take) begin
      slot_valid       <= slot_valid_next;
      slot_vector_reg  <= slot_vector_next;
      slot_error       <= slot_error_next;
      shutdown_pending <= shutdown_pending_next;
    end
  end

endmodule

// File: rtl/geqi_outbuf.sv
// result register with a skid entry so input ready does not depend on output ready
`timescale 1ns / 1ps

module geqi_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  geqi_pkg::res_t push_data,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output geqi_pkg::res_t out_data
);
  import geqi_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic main_free;

  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign main_free = !main_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      // refill from skid first to keep order
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: rtl/guest_exception_queue_and_inject.sv
// top level of the guest exception queue and injection block
//
//   channel | signals                                    | transfer when
//   in      | in_valid in_ready opcode vector error_code | in_valid && in_ready
//   out     | out_valid out_ready status ... set_resume_flag | out_valid && out_ready
//
// one item per cycle while in_ready is high; its result is registered at the transfer
// the slot state updates at the input transfer, so back-to-back items chain
// in_ready comes from a register: a skid entry holds one result during a stall
// rst is synchronous and empties the slot, the shutdown flag and both buffers
`timescale 1ns / 1ps

module guest_exception_queue_and_inject (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic [geqi_pkg::VecW-1:0]          vector,
  input  logic [geqi_pkg::ErrW-1:0]          error_code,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [geqi_pkg::StatusW-1:0]       status,
  output logic [geqi_pkg::SlotVecW-1:0]      slot_vector,
  output logic [31:0]                        entry_info,
  output logic [geqi_pkg::ErrW-1:0]          entry_error_code,
  output logic                               write_error_code,
  output logic                               retain_rip,
  output logic                               set_resume_flag
);
  import geqi_pkg::*;

  logic take;
  res_t core_res;
  res_t out_res;

  assign take = in_valid && in_ready;

  geqi_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .opcode     (opcode),
    .vector     (vector),
    .error_code (error_code),
    .res        (core_res)
  );

  geqi_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign status           = out_res.status;
  assign slot_vector      = out_res.slot_vector;
  assign entry_info       = out_res.entry_info;
  assign entry_error_code = out_res.entry_error_code;
  assign write_error_code = out_res.write_error_code;
  assign retain_rip       = out_res.retain_rip;
  assign set_resume_flag  = out_res.set_resume_flag;

endmodule

// File: rtl/geqi_checker.sv
// port-level checks for the exception slot block and their bind
`timescale 1ns / 1ps

module geqi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [geqi_pkg::StatusW-1:0]  status,
  input logic [geqi_pkg::SlotVecW-1:0] slot_vector,
  input logic [31:0]                   entry_info,
  input logic                          write_error_code,
  input logic                          retain_rip,
  input logic                          set_resume_flag
);
  import geqi_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_info))
    else $error("result changed while stalled");

  // injection side outputs are quiet unless an injection happened
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_INJECTED) |->
      (entry_info == '0) && !write_error_code && !retain_rip)
    else $error("injection fields set without injection");

  // an injection empties the slot and builds a well formed word
  a_inject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INJECTED) |->
      entry_info[31] && (entry_info[10:8] == TYPE_HW_EXC) &&
      (entry_info[11] == write_error_code) && (slot_vector == '0))
    else $error("malformed injection result");

  a_rf_rip: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (retain_rip == set_resume_flag))
    else $error("retain rip and resume flag disagree");

endmodule

bind guest_exception_queue_and_inject geqi_checker u_geqi_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .slot_vector      (slot_vector),
  .entry_info       (entry_info),
  .write_error_code (write_error_code),
  .retain_rip       (retain_rip),
  .set_resume_flag  (set_resume_flag)
);
